FILE: hdl/taie_pkg.sv
// Shared types and constants for the three-address IR executor.
`default_nettype none
package taie_pkg;

    localparam logic [4:0] MODE_ST_VAR = 5'd0;
    localparam logic [4:0] MODE_LD_VAR = 5'd1;
    localparam logic [4:0] MODE_LD_IMM = 5'd2;
    localparam logic [4:0] MODE_LABEL  = 5'd3;
    localparam logic [4:0] MODE_GOTO   = 5'd4;
    localparam logic [4:0] MODE_IFGOTO = 5'd5;
    localparam logic [4:0] MODE_IFNOT  = 5'd6;
    localparam logic [4:0] MODE_ADD    = 5'd7;
    localparam logic [4:0] MODE_SUB    = 5'd8;
    localparam logic [4:0] MODE_MUL    = 5'd9;
    localparam logic [4:0] MODE_DIV    = 5'd10;
    localparam logic [4:0] MODE_REM    = 5'd11;
    localparam logic [4:0] MODE_LT     = 5'd12;
    localparam logic [4:0] MODE_GT     = 5'd13;
    localparam logic [4:0] MODE_EQ     = 5'd14;
    localparam logic [4:0] MODE_NE     = 5'd15;
    localparam logic [4:0] MODE_LE     = 5'd16;
    localparam logic [4:0] MODE_GE     = 5'd17;

    localparam int IdxW = 6;
    localparam int IdxN = 64;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_FIX,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic read;
        logic exec;
        logic div_start;
        logic div_step;
        logic div_fix;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic div_go;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: hdl/taie_ctrl.sv
// Controller state machine sequencing one request at a time.
`default_nettype none
module taie_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire taie_pkg::t_sts i_sts,
    output taie_pkg::t_cmd     o_cmd
);
    import taie_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.div_go) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.div_fix = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule
`default_nettype wire

FILE: hdl/taie_dp.sv
// Datapath: register stores, ALU, iterative divider and output register.
`default_nettype none
module taie_dp #(
    parameter int TEMP_COUNT = 64,
    parameter int VAR_COUNT  = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire taie_pkg::t_cmd     i_cmd,
    output taie_pkg::t_sts          o_sts,
    input  wire logic [4:0]         i_mode,
    input  wire logic [9:0]         i_current_pc,
    input  wire logic [5:0]         i_dest_temp,
    input  wire logic [5:0]         i_src_temp_a,
    input  wire logic [5:0]         i_src_temp_b,
    input  wire logic [5:0]         i_var_index,
    input  wire logic signed [31:0] i_immediate,
    input  wire logic [9:0]         i_branch_target,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [10:0]             o_next_pc,
    output logic signed [31:0]      o_result_value,
    output logic                    o_branch_taken,
    output logic                    o_divide_error
);
    import taie_pkg::*;

    localparam int TW    = (TEMP_COUNT > 1) ? $clog2(TEMP_COUNT) : 1;
    localparam int VW    = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
    localparam int CLR_N = (TEMP_COUNT > VAR_COUNT) ? TEMP_COUNT : VAR_COUNT;
    localparam int CW    = $clog2(CLR_N);

    logic [TW-1:0] tmod [IdxN];
    logic [VW-1:0] vmod [IdxN];

    for (genvar g = 0; g < IdxN; g++) begin : g_mod
        assign tmod[g] = TW'(g % TEMP_COUNT);
        assign vmod[g] = VW'(g % VAR_COUNT);
    end

    logic [31:0] temp_mem [TEMP_COUNT];
    logic [31:0] var_mem  [VAR_COUNT];

    logic [4:0]    r_mode;
    logic [9:0]    r_pc;
    logic [9:0]    r_tgt;
    logic [TW-1:0] r_dt;
    logic [TW-1:0] r_ta;
    logic [TW-1:0] r_tb;
    logic [VW-1:0] r_vi;
    logic [31:0]   r_imm;
    logic [31:0]   r_rd_a;
    logic [31:0]   r_rd_b;
    logic [31:0]   r_rd_v;
    logic [31:0]   r_res;
    logic          r_taken;
    logic          r_derr;
    logic [31:0]   r_dvd;
    logic [31:0]   r_quo;
    logic [31:0]   r_rem;
    logic [4:0]    r_dcnt;
    logic [CW-1:0] r_clr;
    logic          r_o_valid;

    logic          port_a_dt;
    logic [TW-1:0] addr_a;
    logic [31:0]   alu_res;
    logic          alu_taken;
    logic          alu_derr;
    logic          is_div;
    logic [31:0]   mag_a;
    logic [31:0]   mag_b;
    logic [32:0]   rem_sh;
    logic [32:0]   diff;
    logic          qbit;
    logic          neg_a;
    logic          neg_b;
    logic          t_we;
    logic [TW-1:0] t_wa;
    logic [31:0]   t_wd;
    logic          v_we;
    logic [VW-1:0] v_wa;
    logic [31:0]   v_wd;
    logic          writes_temp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_pc   <= i_current_pc;
            r_tgt  <= i_branch_target;
            r_dt   <= tmod[i_dest_temp];
            r_ta   <= tmod[i_src_temp_a];
            r_tb   <= tmod[i_src_temp_b];
            r_vi   <= vmod[i_var_index];
            r_imm  <= i_immediate;
        end
    end

    assign port_a_dt = (r_mode == MODE_ST_VAR) || (r_mode == MODE_IFGOTO)
                    || (r_mode == MODE_IFNOT);
    assign addr_a    = port_a_dt ? r_dt : r_ta;

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_a <= temp_mem[addr_a];
            r_rd_b <= temp_mem[r_tb];
            r_rd_v <= var_mem[r_vi];
        end
    end

    assign is_div = (r_mode == MODE_DIV) || (r_mode == MODE_REM);
    assign neg_a  = r_rd_a[31];
    assign neg_b  = r_rd_b[31];
    assign mag_a  = neg_a ? (~r_rd_a + 32'd1) : r_rd_a;
    assign mag_b  = neg_b ? (~r_rd_b + 32'd1) : r_rd_b;

    always_comb begin
        alu_res   = '0;
        alu_taken = 1'b0;
        alu_derr  = 1'b0;
        unique case (r_mode)
            MODE_ST_VAR: alu_res   = r_rd_a;
            MODE_LD_VAR: alu_res   = r_rd_v;
            MODE_LD_IMM: alu_res   = r_imm;
            MODE_GOTO:   alu_taken = 1'b1;
            MODE_IFGOTO: alu_taken = (r_rd_a != '0);
            MODE_IFNOT:  alu_taken = (r_rd_a == '0);
            MODE_ADD:    alu_res   = r_rd_a + r_rd_b;
            MODE_SUB:    alu_res   = r_rd_a - r_rd_b;
            MODE_MUL:    alu_res   = r_rd_a * r_rd_b;
            MODE_DIV,
            MODE_REM:    alu_derr  = 1'b1;
            MODE_LT:     alu_res   = {31'd0, $signed(r_rd_a) <  $signed(r_rd_b)};
            MODE_GT:     alu_res   = {31'd0, $signed(r_rd_a) >  $signed(r_rd_b)};
            MODE_EQ:     alu_res   = {31'd0, r_rd_a == r_rd_b};
            MODE_NE:     alu_res   = {31'd0, r_rd_a != r_rd_b};
            MODE_LE:     alu_res   = {31'd0, $signed(r_rd_a) <= $signed(r_rd_b)};
            MODE_GE:     alu_res   = {31'd0, $signed(r_rd_a) >= $signed(r_rd_b)};
            default:     alu_res   = '0;
        endcase
    end

    assign rem_sh = {r_rem, r_dvd[31]};
    assign diff   = rem_sh - {1'b0, mag_b};
    assign qbit   = ~diff[32];

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dvd  <= mag_a;
            r_quo  <= '0;
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[30:0], 1'b0};
            r_quo  <= {r_quo[30:0], qbit};
            r_rem  <= qbit ? diff[31:0] : rem_sh[31:0];
            r_dcnt <= r_dcnt + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res   <= alu_res;
            r_taken <= alu_taken;
            r_derr  <= alu_derr;
        end else if (i_cmd.div_fix) begin
            r_taken <= 1'b0;
            r_derr  <= 1'b0;
            if (r_mode == MODE_DIV) begin
                r_res <= (neg_a != neg_b) ? (~r_quo + 32'd1) : r_quo;
            end else begin
                r_res <= neg_a ? (~r_rem + 32'd1) : r_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= r_clr + CW'(1);
        end
    end

    assign writes_temp = (r_mode == MODE_LD_VAR) || (r_mode == MODE_LD_IMM)
                      || ((r_mode >= MODE_ADD) && (r_mode <= MODE_GE));

    always_comb begin
        t_we = 1'b0;
        t_wa = r_dt;
        t_wd = r_res;
        v_we = 1'b0;
        v_wa = r_vi;
        v_wd = r_res;
        if (i_cmd.clear) begin
            t_we = ({1'b0, r_clr} < (CW+1)'(TEMP_COUNT));
            t_wa = r_clr[TW-1:0];
            t_wd = '0;
            v_we = ({1'b0, r_clr} < (CW+1)'(VAR_COUNT));
            v_wa = r_clr[VW-1:0];
            v_wd = '0;
        end else if (i_cmd.finish) begin
            t_we = writes_temp;
            v_we = (r_mode == MODE_ST_VAR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            temp_mem[t_wa] <= t_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            var_mem[v_wa] <= v_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_next_pc      <= r_taken ? {1'b0, r_tgt} : ({1'b0, r_pc} + 11'd1);
            o_result_value <= r_res;
            o_branch_taken <= r_taken;
            o_divide_error <= r_derr;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_sts.clear_last = (r_clr == CW'(CLR_N - 1));
    assign o_sts.div_go     = is_div && (r_rd_b != '0);
    assign o_sts.div_last   = (r_dcnt == 5'd31);
    assign o_sts.out_free   = !r_o_valid || !i_out_stall;

endmodule
`default_nettype wire

FILE: hdl/three_address_ir_executor_core.sv
// Top level of the three-address IR executor.
// Executes one IR instruction per request against a temporary register file and a
// variable store, returning next pc, written value, branch and divide-error flags.
// After reset the block clears both stores, one entry per cycle, over
// max(TEMP_COUNT, VAR_COUNT) entries while o_in_stall is high. After acceptance a
// request is read, executed and loaded into the output register, and a new request
// is accepted only once the previous one has reached the output register. Division
// and remainder by a nonzero divisor run the one-bit-per-cycle restoring divider
// over all 32 quotient bits and then a sign fix-up step before the output register.
// A new request is accepted while an earlier result waits in the output register;
// that request then holds until the output register is free.
`default_nettype none
module three_address_ir_executor_core #(
    parameter int TEMP_COUNT = 64,
    parameter int VAR_COUNT  = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [4:0]         i_mode,
    input  wire logic [9:0]         i_current_pc,
    input  wire logic [5:0]         i_dest_temp,
    input  wire logic [5:0]         i_src_temp_a,
    input  wire logic [5:0]         i_src_temp_b,
    input  wire logic [5:0]         i_var_index,
    input  wire logic signed [31:0] i_immediate,
    input  wire logic [9:0]         i_branch_target,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [10:0]             o_next_pc,
    output logic signed [31:0]      o_result_value,
    output logic                    o_branch_taken,
    output logic                    o_divide_error
);
    import taie_pkg::*;

    t_cmd cmd;
    t_sts sts;

    taie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    taie_dp #(
        .TEMP_COUNT (TEMP_COUNT),
        .VAR_COUNT  (VAR_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_mode          (i_mode),
        .i_current_pc    (i_current_pc),
        .i_dest_temp     (i_dest_temp),
        .i_src_temp_a    (i_src_temp_a),
        .i_src_temp_b    (i_src_temp_b),
        .i_var_index     (i_var_index),
        .i_immediate     (i_immediate),
        .i_branch_target (i_branch_target),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_next_pc       (o_next_pc),
        .o_result_value  (o_result_value),
        .o_branch_taken  (o_branch_taken),
        .o_divide_error  (o_divide_error)
    );

endmodule
`default_nettype wire

FILE: hdl/taie_chk.sv
// Port-level checker for the executor, bound to the top level.
`default_nettype none
module taie_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [10:0] o_next_pc,
    input wire logic [31:0] o_result_value,
    input wire logic        o_branch_taken,
    input wire logic        o_divide_error
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while busy");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_result_value)))
        else $error("stalled result changed");

    a_pc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_branch_taken) |-> (o_next_pc != 11'd0))
        else $error("sequential next pc is zero");

    a_div_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_divide_error) |-> (o_result_value == 32'd0 && !o_branch_taken))
        else $error("divide error with nonzero result");

endmodule

bind three_address_ir_executor_core taie_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_next_pc      (o_next_pc),
    .o_result_value (o_result_value),
    .o_branch_taken (o_branch_taken),
    .o_divide_error (o_divide_error)
);
`default_nettype wire

FILE: sim/three_address_ir_executor_checker.sv
// Checker that predicts and compares results of the three-address IR executor.
`timescale 1ns / 100ps
module three_address_ir_executor_checker
    import taie_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic [4:0]         i_mode,
    input  wire logic [9:0]         i_current_pc,
    input  wire logic [5:0]         i_dest_temp,
    input  wire logic [5:0]         i_src_temp_a,
    input  wire logic [5:0]         i_src_temp_b,
    input  wire logic [5:0]         i_var_index,
    input  wire logic signed [31:0] i_immediate,
    input  wire logic [9:0]         i_branch_target,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic [10:0]        i_next_pc,
    input  wire logic signed [31:0] i_result_value,
    input  wire logic               i_branch_taken,
    input  wire logic               i_divide_error,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic [10:0] next_pc;
        logic [31:0] value;
        logic        taken;
        logic        div_err;
    } t_outcome;

    logic [31:0] temps [IdxN];
    logic [31:0] vars [IdxN];
    t_outcome    outcome_q [$];

    function automatic logic [31:0] alu_value(input logic [4:0] mode, input logic [31:0] a,
                                              input logic [31:0] b);
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        logic [31:0]        ma;
        logic [31:0]        mb;
        logic [31:0]        q;
        logic [31:0]        r;
        sa = a;
        sb = b;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        case (mode)
            MODE_ADD: return a + b;
            MODE_SUB: return a - b;
            MODE_MUL: return a * b;
            MODE_DIV, MODE_REM: begin
                if (b == 0) return 0;
                q = ma / mb;
                r = ma % mb;
                if (mode == MODE_DIV) return (a[31] != b[31]) ? -q : q;
                return a[31] ? -r : r;
            end
            MODE_LT: return {31'd0, sa < sb};
            MODE_GT: return {31'd0, sa > sb};
            MODE_EQ: return {31'd0, a == b};
            MODE_NE: return {31'd0, a != b};
            MODE_LE: return {31'd0, sa <= sb};
            default: return {31'd0, sa >= sb};
        endcase
    endfunction

    function automatic t_outcome execute_instr();
        t_outcome o;
        o.next_pc = {1'b0, i_current_pc} + 11'd1;
        o.value = 0;
        o.taken = 0;
        o.div_err = 0;
        case (i_mode)
            MODE_ST_VAR: begin
                o.value = temps[i_dest_temp];
                vars[i_var_index] = o.value;
            end
            MODE_LD_VAR: begin
                o.value = vars[i_var_index];
                temps[i_dest_temp] = o.value;
            end
            MODE_LD_IMM: begin
                o.value = i_immediate;
                temps[i_dest_temp] = o.value;
            end
            MODE_GOTO:   o.taken = 1;
            MODE_IFGOTO: o.taken = temps[i_dest_temp] != 0;
            MODE_IFNOT:  o.taken = temps[i_dest_temp] == 0;
            default: begin
                if (i_mode >= MODE_ADD && i_mode <= MODE_GE) begin
                    o.value = alu_value(i_mode, temps[i_src_temp_a], temps[i_src_temp_b]);
                    o.div_err = (i_mode == MODE_DIV || i_mode == MODE_REM)
                                && temps[i_src_temp_b] == 0;
                    temps[i_dest_temp] = o.value;
                end
            end
        endcase
        if (o.taken) o.next_pc = {1'b0, i_branch_target};
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            foreach (temps[k]) temps[k] = 0;
            foreach (vars[k]) vars[k] = 0;
            outcome_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (outcome_q.size() == 0) begin
                    $error("result with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (i_next_pc !== want.next_pc) begin
                        $error("next_pc expected %0d actual %0d", want.next_pc, i_next_pc);
                        o_fail_count++;
                    end
                    if (i_result_value !== want.value) begin
                        $error("result_value expected %0d actual %0d",
                               $signed(want.value), i_result_value);
                        o_fail_count++;
                    end
                    if (i_branch_taken !== want.taken) begin
                        $error("branch_taken expected %0b actual %0b", want.taken,
                               i_branch_taken);
                        o_fail_count++;
                    end
                    if (i_divide_error !== want.div_err) begin
                        $error("divide_error expected %0b actual %0b", want.div_err,
                               i_divide_error);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) outcome_q.push_back(execute_instr());
        end
        o_pending = outcome_q.size();
    end

endmodule

FILE: sim/three_address_ir_executor_core_tb.sv
// Testbench top for the three-address IR executor: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module three_address_ir_executor_core_tb;
    import taie_pkg::*;

    localparam int WatchdogLimit = 2000;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic [4:0]         mode = 0;
    logic [9:0]         current_pc = 0;
    logic [5:0]         dest_temp = 0;
    logic [5:0]         src_temp_a = 0;
    logic [5:0]         src_temp_b = 0;
    logic [5:0]         var_index = 0;
    logic signed [31:0] immediate = 0;
    logic [9:0]         branch_target = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [10:0]        next_pc;
    logic signed [31:0] result_value;
    logic               branch_taken;
    logic               divide_error;
    int                 fail_count;
    int                 pending;
    int                 send_idle_pct = 0;
    int                 stall_pct = 0;
    int                 idle_cycles = 0;

    always #5 clk = ~clk;

    three_address_ir_executor_core DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_mode(mode), .i_current_pc(current_pc), .i_dest_temp(dest_temp),
        .i_src_temp_a(src_temp_a), .i_src_temp_b(src_temp_b), .i_var_index(var_index),
        .i_immediate(immediate), .i_branch_target(branch_target),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_next_pc(next_pc), .o_result_value(result_value),
        .o_branch_taken(branch_taken), .o_divide_error(divide_error)
    );

    three_address_ir_executor_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_mode(mode), .i_current_pc(current_pc), .i_dest_temp(dest_temp),
        .i_src_temp_a(src_temp_a), .i_src_temp_b(src_temp_b), .i_var_index(var_index),
        .i_immediate(immediate), .i_branch_target(branch_target),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_next_pc(next_pc), .i_result_value(result_value),
        .i_branch_taken(branch_taken), .i_divide_error(divide_error),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 0;
            4: return $urandom_range(9);
            5: return -$urandom_range(9);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic [4:0] m, input logic [5:0] dt, input logic [5:0] ta,
                                input logic [5:0] tb, input logic [31:0] imm);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        mode <= m;
        current_pc <= 10'($urandom);
        dest_temp <= dt;
        src_temp_a <= ta;
        src_temp_b <= tb;
        var_index <= 6'($urandom);
        immediate <= imm;
        branch_target <= 10'($urandom);
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic random_request();
        logic [4:0] m;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 30) m = MODE_LD_IMM;
        else if (pick < 35) m = 5'($urandom_range(31, 18));
        else if (pick < 50) m = 5'($urandom_range(MODE_IFNOT));
        else m = 5'($urandom_range(MODE_GE, MODE_ADD));
        if (pick < 90) begin
            send_request(m, 6'($urandom_range(7)), 6'($urandom_range(7)),
                         6'($urandom_range(7)), pick_value());
        end else begin
            send_request(m, 6'($urandom), 6'($urandom), 6'($urandom), pick_value());
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed: extremes, every mode, divide special cases
        send_request(MODE_LD_IMM, 1, 0, 0, 32'h8000_0000);
        send_request(MODE_LD_IMM, 2, 0, 0, 32'hffff_ffff);
        send_request(MODE_LD_IMM, 63, 0, 0, 32'h7fff_ffff);
        send_request(MODE_DIV, 3, 1, 2, 0);
        send_request(MODE_REM, 4, 1, 2, 0);
        send_request(MODE_DIV, 5, 1, 0, 0);
        send_request(MODE_REM, 6, 63, 0, 0);
        send_request(MODE_LD_IMM, 7, 0, 0, -7);
        send_request(MODE_LD_IMM, 8, 0, 0, 2);
        send_request(MODE_DIV, 9, 7, 8, 0);
        send_request(MODE_REM, 10, 7, 8, 0);
        send_request(MODE_MUL, 11, 63, 63, 0);
        send_request(MODE_ADD, 12, 63, 2, 0);
        send_request(MODE_SUB, 13, 1, 8, 0);
        for (int m = MODE_LT; m <= MODE_GE; m++) send_request(5'(m), 14, 1, 63, 0);
        send_request(MODE_ST_VAR, 63, 0, 0, 0);
        send_request(MODE_LD_VAR, 0, 0, 0, 0);
        send_request(MODE_LABEL, 0, 0, 0, 0);
        send_request(MODE_GOTO, 0, 0, 0, 0);
        send_request(MODE_IFGOTO, 1, 0, 0, 0);
        send_request(MODE_IFNOT, 0, 0, 0, 0);
        send_request(5'd31, 0, 63, 63, 0);

        for (int phase = 0; phase < 4; phase++) begin
            drain();
            send_idle_pct = (phase == 1) ? 45 : (phase == 3) ? 22 : 0;
            stall_pct = (phase == 2) ? 45 : (phase == 3) ? 22 : 0;
            repeat (320) random_request();
        end
        drain();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
